[rtl/preset_scan_lock_controller_top_macros.svh]
// Assertion macros for the preset scan and lock controller.
// Both sample on clk_i; the first is masked while rst_ni is low.
`ifndef PRESET_SCAN_LOCK_CONTROLLER_TOP_MACROS_SVH
`define PRESET_SCAN_LOCK_CONTROLLER_TOP_MACROS_SVH

// Checked only out of reset
`define PSLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define PSLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/pslc_pkg.sv]
// Shared constants for the preset scan and lock controller.
// Used by the channel interfaces and the top level; no dependencies.
`default_nettype none

package pslc_pkg;

  localparam int MAX_PRESETS_DEF = 16;

  localparam int OPCODE_W = 4;
  localparam int TIME_W   = 32;
  localparam int FREQ_W   = 32;
  localparam int RSSI_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Event codes
  localparam logic [OPCODE_W-1:0] OP_START  = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_NEXT   = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_PREV   = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_TOGGLE = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_STOP   = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_POLL   = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_TUNED  = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_RSSI   = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_FRAME  = 4'd8;
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 4'd9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_MS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FREQ = 2'd2;

  localparam logic [COUNT_W-1:0]    PRESET_COUNT_RST = 5'd1;
  localparam logic [TIME_W-1:0]     DWELL_MS_RST     = 32'd2000;
  localparam logic signed [RSSI_W-1:0] RSSI_FLOOR    = -8'sd127;

endpackage

`default_nettype wire

[rtl/pslc_in_if.sv]
// Event channel of the preset scan and lock controller.
// Depends on pslc_pkg for field widths.
`default_nettype none

interface pslc_in_if;
  import pslc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [TIME_W-1:0]          now_ms;
  logic                       receiver_searching;
  logic signed [RSSI_W-1:0]   rssi_dbm;
  logic [SLOT_W-1:0]          preset_slot;
  logic [FREQ_W-1:0]          preset_freq_hz;

  modport source (
    output valid, opcode, now_ms, receiver_searching, rssi_dbm, preset_slot,
           preset_freq_hz,
    input  ready
  );

  modport sink (
    input  valid, opcode, now_ms, receiver_searching, rssi_dbm, preset_slot,
           preset_freq_hz,
    output ready
  );

endinterface

`default_nettype wire

[rtl/pslc_out_if.sv]
// Status channel of the preset scan and lock controller.
// Depends on pslc_pkg for field widths.
`default_nettype none

interface pslc_out_if;
  import pslc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       scan_on;
  logic                       is_locked;
  logic [INDEX_W-1:0]         current_index;
  logic [FREQ_W-1:0]          current_freq_hz;
  logic [FREQ_W-1:0]          best_freq_hz;
  logic [TIME_W-1:0]          ms_on_frequency;
  logic signed [RSSI_W-1:0]   last_rssi;
  logic signed [RSSI_W-1:0]   best_rssi;
  logic                       advanced;

  modport source (
    output valid, scan_on, is_locked, current_index, current_freq_hz, best_freq_hz,
           ms_on_frequency, last_rssi, best_rssi, advanced,
    input  ready
  );

  modport sink (
    input  valid, scan_on, is_locked, current_index, current_freq_hz, best_freq_hz,
           ms_on_frequency, last_rssi, best_rssi, advanced,
    output ready
  );

endinterface

`default_nettype wire

[rtl/preset_scan_lock_controller_top.sv]
// Preset scan and lock controller. One event per transfer, one status transfer back.
// Each event passes EXEC, RD and FIN; next preset and a stepping scan poll add one MOD
// step per remainder bit (serial remainder), start adds an SRD read and SCMP compare per
// table entry searched. A new event is taken only in IDLE, after FIN hands off status.
// Reset: asynchronous, active low; clears mode, index, tune time and strengths, and
// returns the registers to their defaults. The preset table is not cleared.
`default_nettype none

`include "preset_scan_lock_controller_top_macros.svh"

module preset_scan_lock_controller_top #(
  parameter int MAX_PRESETS = pslc_pkg::MAX_PRESETS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [pslc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [pslc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  pslc_in_if.sink                           in_i,
  pslc_out_if.source                        out_o
);
  import pslc_pkg::*;

  localparam int IDX_W = (MAX_PRESETS > 1) ? $clog2(MAX_PRESETS) : 1;
  localparam int NW    = IDX_W + 1;
  localparam int SW    = NW + IDX_W;
  localparam int BW    = $clog2(IDX_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SRD  = 3'd2;
  localparam logic [2:0] S_SCMP = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // Configuration
  logic [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]  dwell_q;
  logic [FREQ_W-1:0]  dflt_q;

  // Controller state
  logic [2:0]               state_q, state_d;
  logic [IDX_W-1:0]         index_q, index_d;
  logic                     scan_q, scan_d;
  logic                     lock_q, lock_d;
  logic [TIME_W-1:0]        tune_q, tune_d;
  logic signed [RSSI_W-1:0] recent_q, recent_d;
  logic signed [RSSI_W-1:0] peak_q, peak_d;
  logic [FREQ_W-1:0]        peak_freq_q, peak_freq_d;
  logic                     peak_load_q, peak_load_d;
  logic                     stepped_q, stepped_d;
  logic [IDX_W-1:0]         cnt_q, cnt_d;
  logic [NW-1:0]            rem_q, rem_d;
  logic [BW-1:0]            bcnt_q, bcnt_d;

  // Latched event
  logic [OPCODE_W-1:0]      op_q;
  logic [TIME_W-1:0]        now_q;
  logic                     srch_q;
  logic signed [RSSI_W-1:0] rssi_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [FREQ_W-1:0]        wfreq_q;

  // Preset table
  logic [FREQ_W-1:0] table_mem [MAX_PRESETS];
  logic [FREQ_W-1:0] rdata_q;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  // Status register
  logic                     out_valid_q;
  logic                     fin_go;

  logic [NW-1:0]            n_live;
  logic                     in_xfer;
  logic                     poll_step;
  logic [SW-1:0]            div_sh;
  logic [SW-1:0]            rem_ext;
  logic [NW-1:0]            rem_next;

  assign in_xfer = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign fin_go = !out_valid_q || out_o.ready;

  always_comb begin
    if (count_q == '0) begin
      n_live = NW'(1);
    end else if (32'(count_q) > MAX_PRESETS) begin
      n_live = NW'(MAX_PRESETS);
    end else begin
      n_live = NW'(count_q);
    end
  end

  assign poll_step = scan_q && !lock_q && srch_q &&
                     ((tune_q == '0) || ((now_q - tune_q) >= dwell_q));

  // One bit of the remainder per cycle
  assign div_sh  = SW'(n_live) << bcnt_q;
  assign rem_ext = SW'(rem_q);
  assign rem_next = (rem_ext >= div_sh) ? NW'(rem_ext - div_sh) : rem_q;

  assign wr_en   = (state_q == S_EXEC) && (op_q == OP_WRITE) && (32'(slot_q) < MAX_PRESETS);
  assign wr_addr = IDX_W'(slot_q);
  assign rd_en   = (state_q == S_SRD) || (state_q == S_RD);
  assign rd_addr = (state_q == S_SRD) ? cnt_q : index_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wfreq_q;
    end
    if (rd_en) begin
      rdata_q <= table_mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    index_d     = index_q;
    scan_d      = scan_q;
    lock_d      = lock_q;
    tune_d      = tune_q;
    recent_d    = recent_q;
    peak_d      = peak_q;
    peak_freq_d = peak_freq_q;
    peak_load_d = peak_load_q;
    stepped_d   = stepped_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    bcnt_d      = bcnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          peak_load_d = 1'b0;
          stepped_d   = 1'b0;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RD;
        case (op_q)
          OP_START: begin
            scan_d      = 1'b0;
            lock_d      = 1'b0;
            tune_d      = now_q;
            recent_d    = RSSI_FLOOR;
            peak_d      = RSSI_FLOOR;
            peak_load_d = 1'b1;
            cnt_d       = '0;
            state_d     = S_SRD;
          end
          OP_NEXT: begin
            scan_d  = 1'b0;
            lock_d  = 1'b0;
            rem_d   = NW'(index_q) + NW'(1);
            bcnt_d  = BW'(IDX_W);
            state_d = S_MOD;
          end
          OP_PREV: begin
            scan_d  = 1'b0;
            lock_d  = 1'b0;
            index_d = (index_q == '0) ? IDX_W'(n_live - NW'(1)) : index_q - IDX_W'(1);
          end
          OP_TOGGLE: begin
            scan_d = !scan_q;
            lock_d = 1'b0;
            if (!scan_q) begin
              peak_d      = RSSI_FLOOR;
              peak_load_d = 1'b1;
              tune_d      = '0;
            end
          end
          OP_STOP: begin
            scan_d = 1'b0;
            lock_d = 1'b0;
          end
          OP_POLL: begin
            if (poll_step) begin
              tune_d    = now_q;
              recent_d  = RSSI_FLOOR;
              stepped_d = 1'b1;
              rem_d     = NW'(index_q) + NW'(1);
              bcnt_d    = BW'(IDX_W);
              state_d   = S_MOD;
            end
          end
          OP_TUNED: begin
            tune_d   = now_q;
            recent_d = RSSI_FLOOR;
          end
          OP_RSSI: begin
            recent_d = rssi_q;
            if (rssi_q > peak_q) begin
              peak_d      = rssi_q;
              peak_load_d = 1'b1;
            end
          end
          OP_FRAME: begin
            recent_d = rssi_q;
            if (rssi_q > peak_q) begin
              peak_d      = rssi_q;
              peak_load_d = 1'b1;
            end
            tune_d = now_q;
            if (scan_q) begin
              scan_d = 1'b0;
              lock_d = 1'b1;
            end
          end
          default: begin
            // table write and unknown codes leave the control state alone
          end
        endcase
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (rdata_q == dflt_q) begin
          index_d = cnt_q;
          state_d = S_RD;
        end else if (NW'(cnt_q) == n_live - NW'(1)) begin
          index_d = '0;
          state_d = S_RD;
        end else begin
          cnt_d   = cnt_q + IDX_W'(1);
          state_d = S_SRD;
        end
      end
      S_MOD: begin
        rem_d = rem_next;
        if (bcnt_q == '0) begin
          index_d = IDX_W'(rem_next);
          state_d = S_RD;
        end else begin
          bcnt_d = bcnt_q - BW'(1);
        end
      end
      S_RD: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (peak_load_q) begin
          peak_freq_d = rdata_q;
          peak_load_d = 1'b0;
        end
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= PRESET_COUNT_RST;
      dwell_q     <= DWELL_MS_RST;
      dflt_q      <= '0;
      state_q     <= S_IDLE;
      index_q     <= '0;
      scan_q      <= 1'b0;
      lock_q      <= 1'b0;
      tune_q      <= '0;
      recent_q    <= RSSI_FLOOR;
      peak_q      <= RSSI_FLOOR;
      peak_freq_q <= '0;
      peak_load_q <= 1'b0;
      stepped_q   <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PRESET_COUNT: count_q <= cfg_wdata_i[COUNT_W-1:0];
          REG_DWELL_MS:     dwell_q <= cfg_wdata_i[TIME_W-1:0];
          REG_DEFAULT_FREQ: dflt_q  <= cfg_wdata_i[FREQ_W-1:0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      index_q     <= index_d;
      scan_q      <= scan_d;
      lock_q      <= lock_d;
      tune_q      <= tune_d;
      recent_q    <= recent_d;
      peak_q      <= peak_d;
      peak_freq_q <= peak_freq_d;
      peak_load_q <= peak_load_d;
      stepped_q   <= stepped_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      bcnt_q      <= bcnt_d;
      if (state_q == S_FIN && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event fields and status payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= in_i.opcode;
      now_q   <= in_i.now_ms;
      srch_q  <= in_i.receiver_searching;
      rssi_q  <= in_i.rssi_dbm;
      slot_q  <= in_i.preset_slot;
      wfreq_q <= in_i.preset_freq_hz;
    end
    if (state_q == S_FIN && fin_go) begin
      out_o.scan_on         <= scan_q;
      out_o.is_locked       <= lock_q;
      out_o.current_index   <= INDEX_W'(index_q);
      out_o.current_freq_hz <= rdata_q;
      out_o.best_freq_hz    <= peak_load_q ? rdata_q : peak_freq_q;
      out_o.ms_on_frequency <= (now_q >= tune_q) ? (now_q - tune_q) : '0;
      out_o.last_rssi       <= recent_q;
      out_o.best_rssi       <= peak_q;
      out_o.advanced        <= stepped_q;
    end
  end

  assign out_o.valid = out_valid_q;

  `PSLC_ASSERT(a_mode_exclusive, !(scan_q && lock_q), "scan and lock both set")
  `PSLC_ASSERT(a_index_range, 32'(index_q) < MAX_PRESETS, "preset index beyond table")
  `PSLC_ASSERT(a_mod_result, (state_q == S_MOD && bcnt_q == '0) |=> NW'(index_q) < n_live, "remainder not below preset count")
  `PSLC_ASSERT(a_fin_handoff, (state_q == S_FIN && fin_go) |=> (state_q == S_IDLE && out_valid_q), "status not handed to output register")
  `PSLC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE && !out_valid_q), "not idle in reset")

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for preset_scan_lock_controller_top: drives event transfers,
// predicts every status transfer in-line and compares field by field.
// Depends on pslc_pkg and the pslc_in_if / pslc_out_if channel interfaces.
module tb_top;
  import pslc_pkg::*;

  localparam int          SETTLE_CYCLES = 48;  // start search over a full table, plus margin
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          RAND_PHASES   = 12;
  localparam int          PHASE_EVENTS  = 150;
  localparam logic [OPCODE_W-1:0] OP_TOP_CODE = '1;

  typedef struct {
    logic [OPCODE_W-1:0]      opcode;
    logic [TIME_W-1:0]        now;
    logic                     searching;
    logic signed [RSSI_W-1:0] rssi;
    logic [SLOT_W-1:0]        slot;
    logic [FREQ_W-1:0]        freq;
  } ctl_event_t;

  typedef struct {
    logic                     scan_on;
    logic                     is_locked;
    logic [INDEX_W-1:0]       current_index;
    logic [FREQ_W-1:0]        current_freq_hz;
    logic [FREQ_W-1:0]        best_freq_hz;
    logic [TIME_W-1:0]        ms_on_frequency;
    logic signed [RSSI_W-1:0] last_rssi;
    logic signed [RSSI_W-1:0] best_rssi;
    logic                     advanced;
  } ctl_status_t;

  logic                  clk_i;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pslc_in_if  ev_bus ();
  pslc_out_if st_bus ();

  preset_scan_lock_controller_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (ev_bus),
    .out_o       (st_bus)
  );

  // Predicted controller state and register copies
  logic [COUNT_W-1:0]       cfg_count;
  logic [TIME_W-1:0]        cfg_dwell;
  logic [FREQ_W-1:0]        cfg_dflt;
  logic [INDEX_W-1:0]       chan_idx;
  logic                     scan_mode;
  logic                     lock_mode;
  logic [TIME_W-1:0]        tune_ms;
  logic signed [RSSI_W-1:0] recent_dbm;
  logic signed [RSSI_W-1:0] peak_dbm;
  logic [FREQ_W-1:0]        peak_freq;
  logic [FREQ_W-1:0]        chan_table [MAX_PRESETS_DEF];

  ctl_status_t status_due [$];

  int unsigned cycle_cnt = 0;
  int unsigned events_sent;
  int unsigned status_checked;
  int unsigned steps_seen;
  int unsigned config_sets;
  int unsigned mismatches;
  int unsigned fail_count;
  int unsigned calm_left;
  logic [TIME_W-1:0] sim_ms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("preset_scan_lock_controller_top verification failed");
      $finish;
    end
  end

  function automatic logic [FREQ_W-1:0] band_freq(input int slot);
    return FREQ_W'(433_050_000 + slot * 25_000);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void log_frame(input logic signed [RSSI_W-1:0] dbm);
    recent_dbm = dbm;
    if (dbm > peak_dbm) begin
      peak_dbm  = dbm;
      peak_freq = chan_table[chan_idx];
    end
  endfunction

  // Applies one event to the predicted state and returns the status it reports
  function automatic ctl_status_t predict_status(input ctl_event_t ev);
    ctl_status_t st;
    int span;
    logic [TIME_W-1:0] elapsed;
    logic stepped;
    span = (cfg_count == '0) ? 1 :
           (cfg_count > MAX_PRESETS_DEF) ? MAX_PRESETS_DEF : int'(cfg_count);
    stepped = 1'b0;
    elapsed = ev.now - tune_ms;  // modulo 2^32 on purpose
    case (ev.opcode)
      OP_START: begin
        chan_idx = '0;
        // walk down so the lowest matching entry wins
        for (int i = span - 1; i >= 0; i--)
          if (chan_table[i] == cfg_dflt) chan_idx = INDEX_W'(i);
        scan_mode  = 1'b0;
        lock_mode  = 1'b0;
        tune_ms    = ev.now;
        recent_dbm = RSSI_FLOOR;
        peak_dbm   = RSSI_FLOOR;
        peak_freq  = chan_table[chan_idx];
      end
      OP_NEXT: begin
        chan_idx  = INDEX_W'((int'(chan_idx) + 1) % span);
        scan_mode = 1'b0;
        lock_mode = 1'b0;
      end
      OP_PREV: begin
        chan_idx  = (chan_idx == '0) ? INDEX_W'(span - 1) : chan_idx - 1'b1;
        scan_mode = 1'b0;
        lock_mode = 1'b0;
      end
      OP_TOGGLE: begin
        scan_mode = !scan_mode;
        lock_mode = 1'b0;
        if (scan_mode) begin
          peak_dbm  = RSSI_FLOOR;
          peak_freq = chan_table[chan_idx];
          tune_ms   = '0;
        end
      end
      OP_STOP: begin
        scan_mode = 1'b0;
        lock_mode = 1'b0;
      end
      OP_POLL: begin
        if (scan_mode && !lock_mode && ev.searching &&
            (tune_ms == '0 || elapsed >= cfg_dwell)) begin
          chan_idx   = INDEX_W'((int'(chan_idx) + 1) % span);
          tune_ms    = ev.now;
          recent_dbm = RSSI_FLOOR;
          stepped    = 1'b1;
        end
      end
      OP_TUNED: begin
        tune_ms    = ev.now;
        recent_dbm = RSSI_FLOOR;
      end
      OP_RSSI: log_frame(ev.rssi);
      OP_FRAME: begin
        log_frame(ev.rssi);
        tune_ms = ev.now;
        if (scan_mode) begin
          scan_mode = 1'b0;
          lock_mode = 1'b1;
        end
      end
      OP_WRITE: chan_table[ev.slot] = ev.freq;
      default: ;
    endcase
    st.scan_on         = scan_mode;
    st.is_locked       = lock_mode;
    st.current_index   = chan_idx;
    st.current_freq_hz = chan_table[chan_idx];
    st.best_freq_hz    = peak_freq;
    st.ms_on_frequency = (ev.now >= tune_ms) ? ev.now - tune_ms : '0;
    st.last_rssi       = recent_dbm;
    st.best_rssi       = peak_dbm;
    st.advanced        = stepped;
    if (stepped) steps_seen++;
    return st;
  endfunction

  function automatic ctl_event_t mk_event(input logic [OPCODE_W-1:0] op,
                                          input logic [TIME_W-1:0] now,
                                          input logic searching,
                                          input logic signed [RSSI_W-1:0] rssi,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [FREQ_W-1:0] freq);
    ctl_event_t ev;
    ev.opcode    = op;
    ev.now       = now;
    ev.searching = searching;
    ev.rssi      = rssi;
    ev.slot      = slot;
    ev.freq      = freq;
    return ev;
  endfunction

  // One event transfer; the expected status is queued at the accepting edge
  task automatic send_event(input ctl_event_t ev);
    int unsigned gap;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 99) < 5) begin
      calm_left = $urandom_range(20, 100);
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    repeat (gap) begin
      @(negedge clk_i);
      ev_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    ev_bus.valid              <= 1'b1;
    ev_bus.opcode             <= ev.opcode;
    ev_bus.now_ms             <= ev.now;
    ev_bus.receiver_searching <= ev.searching;
    ev_bus.rssi_dbm           <= ev.rssi;
    ev_bus.preset_slot        <= ev.slot;
    ev_bus.preset_freq_hz     <= ev.freq;
    do @(posedge clk_i); while (!ev_bus.ready);
    status_due.push_back(predict_status(ev));
    events_sent++;
  endtask

  task automatic settle_outputs();
    @(negedge clk_i);
    ev_bus.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers while the controller is idle
  task automatic set_config(input logic [COUNT_W-1:0] count, input logic [TIME_W-1:0] dwell,
                            input logic [FREQ_W-1:0] dflt);
    settle_outputs();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_PRESET_COUNT;
    cfg_wdata <= {(CFG_DATA_W - COUNT_W)'($urandom), count};  // upper bits are ignored
    @(negedge clk_i);
    cfg_idx   <= REG_DWELL_MS;
    cfg_wdata <= dwell;
    @(negedge clk_i);
    cfg_idx   <= REG_DEFAULT_FREQ;
    cfg_wdata <= dflt;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cfg_count = count;
    cfg_dwell = dwell;
    cfg_dflt  = dflt;
    config_sets++;
  endtask

  // Status channel back-pressure
  initial begin
    int unsigned hold;
    st_bus.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 99) < 6) begin
        hold = $urandom_range(20, 150);
        repeat (hold) begin
          @(negedge clk_i);
          st_bus.ready <= 1'b1;
        end
      end else begin
        hold = pick_gap();
        repeat (hold) begin
          @(negedge clk_i);
          st_bus.ready <= 1'b0;
        end
        @(negedge clk_i);
        st_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : status_check
    ctl_status_t got;
    ctl_status_t want;
    string bad;
    if (rst_n && st_bus.valid && st_bus.ready) begin
      got.scan_on         = st_bus.scan_on;
      got.is_locked       = st_bus.is_locked;
      got.current_index   = st_bus.current_index;
      got.current_freq_hz = st_bus.current_freq_hz;
      got.best_freq_hz    = st_bus.best_freq_hz;
      got.ms_on_frequency = st_bus.ms_on_frequency;
      got.last_rssi       = st_bus.last_rssi;
      got.best_rssi       = st_bus.best_rssi;
      got.advanced        = st_bus.advanced;
      if (status_due.size() == 0) begin
        fail_count++;
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] status transfer with nothing outstanding: idx=%0d cur=%h",
                   $realtime, got.current_index, got.current_freq_hz);
      end else begin
        want = status_due.pop_front();
        status_checked++;
        bad = "";
        if (got.scan_on !== want.scan_on) bad = {bad, " scan_on"};
        if (got.is_locked !== want.is_locked) bad = {bad, " is_locked"};
        if (got.current_index !== want.current_index) bad = {bad, " current_index"};
        if (got.current_freq_hz !== want.current_freq_hz) bad = {bad, " current_freq_hz"};
        if (got.best_freq_hz !== want.best_freq_hz) bad = {bad, " best_freq_hz"};
        if (got.ms_on_frequency !== want.ms_on_frequency) bad = {bad, " ms_on_frequency"};
        if (got.last_rssi !== want.last_rssi) bad = {bad, " last_rssi"};
        if (got.best_rssi !== want.best_rssi) bad = {bad, " best_rssi"};
        if (got.advanced !== want.advanced) bad = {bad, " advanced"};
        if (bad != "") begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] status mismatch on%s", $realtime, bad);
            $display("  exp scan=%b lock=%b idx=%0d cur=%h best=%h ms=%h last=%0d peak=%0d adv=%b",
                     want.scan_on, want.is_locked, want.current_index, want.current_freq_hz,
                     want.best_freq_hz, want.ms_on_frequency, want.last_rssi,
                     want.best_rssi, want.advanced);
            $display("  got scan=%b lock=%b idx=%0d cur=%h best=%h ms=%h last=%0d peak=%0d adv=%b",
                     got.scan_on, got.is_locked, got.current_index, got.current_freq_hz,
                     got.best_freq_hz, got.ms_on_frequency, got.last_rssi,
                     got.best_rssi, got.advanced);
          end
        end
      end
    end
  end

  // Every entry is written before anything else, slot zero first, so no event reads an
  // entry that holds nothing yet
  task automatic test_fill_table();
    logic [FREQ_W-1:0] f;
    for (int s = 0; s < MAX_PRESETS_DEF; s++) begin
      f = (s == 0) ? '0 : (s == MAX_PRESETS_DEF - 1) ? '1 : band_freq(s);
      send_event(mk_event(OP_WRITE, TIME_W'(s * 3), s[0], RSSI_W'(s), SLOT_W'(s), f));
    end
  endtask

  task automatic test_start_search();
    set_config(5'd16, 32'd2000, band_freq(5));
    send_event(mk_event(OP_START, 32'd1000, 1'b0, 8'sd0, '0, '0));
    // default not in the table: falls back to preset zero
    set_config(5'd16, 32'd2000, 32'h0BAD_F00D);
    send_event(mk_event(OP_START, 32'd1100, 1'b1, 8'sd0, '0, '0));
  endtask

  task automatic test_wraparound();
    set_config(5'd3, 32'd2000, band_freq(5));
    send_event(mk_event(OP_START, 32'd1200, 1'b0, 8'sd0, '0, '0));
    send_event(mk_event(OP_PREV, 32'd1300, 1'b0, 8'sd0, '0, '0));
    send_event(mk_event(OP_NEXT, 32'd1400, 1'b0, 8'sd0, '0, '0));
  endtask

  // zero count behaves as one, anything above the table size as the table size
  task automatic test_count_limits();
    set_config(5'd0, 32'd2000, '0);
    send_event(mk_event(OP_NEXT, 32'd1500, 1'b0, 8'sd0, '0, '0));
    send_event(mk_event(OP_PREV, 32'd1600, 1'b0, 8'sd0, '0, '0));
    set_config(5'd31, 32'd2000, '0);
    send_event(mk_event(OP_PREV, 32'd1700, 1'b0, 8'sd0, '0, '0));
    send_event(mk_event(OP_NEXT, 32'd1800, 1'b0, 8'sd0, '0, '0));
  endtask

  // index left past the end after the count shrinks
  task automatic test_shrink_index();
    set_config(5'd16, 32'd2000, band_freq(12));
    send_event(mk_event(OP_START, 32'd1900, 1'b0, 8'sd0, '0, '0));
    set_config(5'd4, 32'd2000, band_freq(12));
    send_event(mk_event(OP_PREV, 32'd2000, 1'b0, 8'sd0, '0, '0));
    send_event(mk_event(OP_NEXT, 32'd2100, 1'b0, 8'sd0, '0, '0));
  endtask

  task automatic test_scan_dwell();
    set_config(5'd16, 32'd2000, '0);
    send_event(mk_event(OP_TOGGLE, 32'd5000, 1'b1, 8'sd0, '0, '0));
    send_event(mk_event(OP_POLL, 32'd5000, 1'b1, 8'sd0, '0, '0));   // zero tune time
    send_event(mk_event(OP_POLL, 32'd5001, 1'b1, 8'sd0, '0, '0));
    send_event(mk_event(OP_POLL, 32'd9000, 1'b0, 8'sd0, '0, '0));   // signal present
    send_event(mk_event(OP_POLL, 32'd7000, 1'b1, 8'sd0, '0, '0));   // exactly one dwell
    send_event(mk_event(OP_RSSI, 32'd7100, 1'b1, -8'sd128, '0, '0));
    send_event(mk_event(OP_RSSI, 32'd7150, 1'b1, 8'sd127, '0, '0));
    send_event(mk_event(OP_FRAME, 32'd7200, 1'b1, 8'sd10, '0, '0));
    send_event(mk_event(OP_POLL, 32'd20000, 1'b1, 8'sd0, '0, '0));  // locked, no step
    send_event(mk_event(OP_TOGGLE, 32'd20000, 1'b1, 8'sd0, '0, '0));
    send_event(mk_event(OP_TUNED, 32'd100, 1'b1, 8'sd0, '0, '0));
    send_event(mk_event(OP_POLL, 32'd50, 1'b1, 8'sd0, '0, '0));     // difference wraps
    send_event(mk_event(OP_RSSI, 32'd40, 1'b1, -8'sd60, '0, '0));   // now behind tune time
    send_event(mk_event(OP_STOP, 32'hFFFF_FFFF, 1'b0, 8'sd0, '0, '0));
    send_event(mk_event(OP_TOP_CODE, 32'd0, 1'b1, 8'sd5, '1, '1));
  endtask

  function automatic logic [TIME_W-1:0] advance_clock();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)       sim_ms = $urandom;
    else if (r < 30) sim_ms += $urandom_range(0, 50);
    else             sim_ms += $urandom_range(0, 3000);
    return sim_ms;
  endfunction

  function automatic ctl_event_t rand_event();
    ctl_event_t ev;
    int unsigned r;
    ev.now       = advance_clock();
    ev.searching = ($urandom_range(0, 9) < 8);
    ev.rssi      = RSSI_W'($urandom);
    ev.slot      = SLOT_W'($urandom);
    ev.freq      = ($urandom_range(0, 1) != 0) ? band_freq($urandom_range(0, 15)) : $urandom;
    r = $urandom_range(0, 99);
    if (!scan_mode && !lock_mode && r < 25) ev.opcode = OP_TOGGLE;  // open a scan
    else if (r < 3)  ev.opcode = OP_TOGGLE;
    else if (r < 40) ev.opcode = OP_POLL;
    else if (r < 55) ev.opcode = OP_RSSI;
    else if (r < 60) ev.opcode = OP_FRAME;
    else if (r < 66) ev.opcode = OP_TUNED;
    else if (r < 71) ev.opcode = OP_NEXT;
    else if (r < 76) ev.opcode = OP_PREV;
    else if (r < 80) ev.opcode = OP_STOP;
    else if (r < 84) ev.opcode = OP_START;
    else if (r < 93) ev.opcode = OP_WRITE;
    else if (r < 96) ev.opcode = OPCODE_W'($urandom_range(int'(OP_WRITE) + 1, int'(OP_TOP_CODE)));
    else begin
      ev.opcode = OPCODE_W'($urandom);
      ev.now    = $urandom;
    end
    return ev;
  endfunction

  task automatic test_random_scans();
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  dwell;
    logic [FREQ_W-1:0]  dflt;
    int unsigned r;
    for (int p = 0; p < RAND_PHASES; p++) begin
      r = $urandom_range(0, 99);
      case (p)
        0: count = 5'd1;
        1: count = 5'd16;
        2: count = 5'd0;
        3: count = 5'd31;
        default: count = (r < 60) ? COUNT_W'($urandom_range(1, 16)) : COUNT_W'($urandom);
      endcase
      r = $urandom_range(0, 99);
      case (p)
        0: dwell = '0;
        1: dwell = '1;
        2: dwell = 32'd2000;
        default:
          if (r < 40)      dwell = $urandom_range(1, 4000);
          else if (r < 60) dwell = '0;
          else if (r < 80) dwell = $urandom_range(0, 200);
          else             dwell = $urandom;
      endcase
      case (p)
        0: dflt = '0;
        1: dflt = '1;
        default:
          dflt = ($urandom_range(0, 9) < 6) ? chan_table[$urandom_range(0, 15)] : $urandom;
      endcase
      set_config(count, dwell, dflt);
      repeat (PHASE_EVENTS) send_event(rand_event());
    end
  endtask

  initial begin
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_idx                   = '0;
    cfg_wdata                 = '0;
    ev_bus.valid              = 1'b0;
    ev_bus.opcode             = '0;
    ev_bus.now_ms             = '0;
    ev_bus.receiver_searching = 1'b0;
    ev_bus.rssi_dbm           = '0;
    ev_bus.preset_slot        = '0;
    ev_bus.preset_freq_hz     = '0;
    events_sent    = 0;
    status_checked = 0;
    steps_seen     = 0;
    config_sets    = 0;
    mismatches     = 0;
    fail_count     = 0;
    calm_left      = 0;
    sim_ms         = '0;
    cfg_count  = PRESET_COUNT_RST;
    cfg_dwell  = DWELL_MS_RST;
    cfg_dflt   = '0;
    chan_idx   = '0;
    scan_mode  = 1'b0;
    lock_mode  = 1'b0;
    tune_ms    = '0;
    recent_dbm = RSSI_FLOOR;
    peak_dbm   = RSSI_FLOOR;
    peak_freq  = '0;
    foreach (chan_table[i]) chan_table[i] = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    test_fill_table();
    test_start_search();
    test_wraparound();
    test_count_limits();
    test_shrink_index();
    test_scan_dwell();
    test_random_scans();
    settle_outputs();

    if (status_due.size() != 0) begin
      fail_count++;
      $display("%0d expected status transfers never arrived", status_due.size());
    end
    $display("Ran %0d events under %0d register settings; %0d status transfers checked.",
             events_sent, config_sets, status_checked);
    $display("Scan polls stepped %0d times; %0d mismatches.", steps_seen, mismatches);
    if (fail_count == 0) begin
      $display("preset_scan_lock_controller_top verification clean");
    end else begin
      $display("preset_scan_lock_controller_top verification failed");
    end
    $finish;
  end

endmodule
